[hdl/gha_pkg.sv]
package gha_pkg;

    // Handle layout: generation above slot index.
    localparam int SLOT_BITS  = 6;
    localparam int GEN_BITS   = 10;
    localparam int HANDLE_W   = 16;
    localparam int LIVE_W     = 6;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int FILL_W     = SLOT_BITS + 1;
    localparam int ENTRY_W    = GEN_BITS + 2;
    localparam int HCAT_W     = GEN_BITS + SLOT_BITS;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COMMIT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [GEN_BITS-1:0]  gen_t;
    typedef logic [FILL_W-1:0]    fill_t;

    // One slot table entry.
    typedef struct packed {
        gen_t gen;
        logic alive;
        logic pend;
    } entry_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] new_handle;
        logic                is_alive;
        logic                is_pending;
        logic [LIVE_W-1:0]   live_total;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;
        logic pop;
        logic exec;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic needs_pop;
        logic out_free;
    } dp_status_t;

    function automatic slot_t handle_slot(input logic [HANDLE_W-1:0] h);
        return h[SLOT_BITS-1:0];
    endfunction

    function automatic gen_t handle_gen(input logic [HANDLE_W-1:0] h);
        logic [HCAT_W-1:0] ext;
        ext = HCAT_W'(h);
        return ext[HCAT_W-1:SLOT_BITS];
    endfunction

    function automatic logic [HANDLE_W-1:0] make_handle(input gen_t g, input slot_t s);
        return HANDLE_W'({g, s});
    endfunction

endpackage

[hdl/gha_ram.sv]
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/gha_ctrl.sv]
module gha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  gha_pkg::dp_status_t stat,
    output gha_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Commands follow directly from the state, qualified by req_valid and out_free.
    assign req_ready  = (state_reg == ST_IDLE);
    assign cmd.accept = (state_reg == ST_IDLE) && req_valid;
    assign cmd.pop    = (state_reg == ST_POP);
    assign cmd.exec   = (state_reg == ST_EXEC) && stat.out_free;

    // A reserve that pops the free stack takes an extra read state, ST_POP.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = stat.needs_pop ? ST_POP : ST_EXEC;
                end
            end
            ST_POP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/gha_datapath.sv]
module gha_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  gha_pkg::req_t       req,
    input  gha_pkg::ctrl_cmd_t  cmd,
    output gha_pkg::dp_status_t stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output gha_pkg::rsp_t       rsp
);

    gha_pkg::req_t                     req_reg;
    gha_pkg::slot_t                    slot_reg;
    logic                              full_reg;
    gha_pkg::fill_t                    fill_reg;
    gha_pkg::fill_t                    fresh_reg;
    logic [gha_pkg::SLOT_BITS-1:0]     count_reg;
    logic [gha_pkg::SLOT_COUNT-1:0]    tbl_valid_reg;
    gha_pkg::rsp_t                     rsp_reg;
    logic                              rsp_valid_reg;

    logic                              is_reserve_in;
    logic                              fresh_avail;
    gha_pkg::slot_t                    accept_slot;
    gha_pkg::slot_t                    stack_rd_addr;
    gha_pkg::slot_t                    stack_rd_data;
    gha_pkg::slot_t                    tbl_rd_addr;
    logic [gha_pkg::ENTRY_W-1:0]       tbl_rd_data;
    gha_pkg::entry_t                   cur;
    gha_pkg::entry_t                   nxt;
    logic                              current;
    logic                              tbl_wr;
    logic                              push;
    logic                              cnt_inc;
    logic                              cnt_dec;
    logic [gha_pkg::SLOT_BITS-1:0]     count_next;
    gha_pkg::rsp_t                     rsp_next;

    // Decode of the item being offered.
    assign is_reserve_in  = (req.func == gha_pkg::FUNC_RESERVE);
    assign fresh_avail    = (fresh_reg < gha_pkg::FILL_W'(gha_pkg::SLOT_COUNT));
    assign accept_slot    = is_reserve_in ? fresh_reg[gha_pkg::SLOT_BITS-1:0]
                                          : gha_pkg::handle_slot(req.handle);
    assign stack_rd_addr  = gha_pkg::SLOT_BITS'(fill_reg - gha_pkg::FILL_W'(1));
    assign tbl_rd_addr    = cmd.pop ? stack_rd_data : accept_slot;

    assign stat.needs_pop = is_reserve_in && (fill_reg != '0);
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

    // Slot table: generation plus alive and pending flags.
    gha_ram #(
        .WIDTH (gha_pkg::ENTRY_W),
        .DEPTH (gha_pkg::SLOT_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.exec && tbl_wr),
        .wr_addr (slot_reg),
        .wr_data (nxt),
        .rd_en   (cmd.accept || cmd.pop),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // LIFO of freed slots.
    gha_ram #(
        .WIDTH (gha_pkg::SLOT_BITS),
        .DEPTH (gha_pkg::SLOT_COUNT)
    ) u_stack (
        .clk     (clk),
        .wr_en   (cmd.exec && push),
        .wr_addr (fill_reg[gha_pkg::SLOT_BITS-1:0]),
        .wr_data (slot_reg),
        .rd_en   (cmd.accept && stat.needs_pop),
        .rd_addr (stack_rd_addr),
        .rd_data (stack_rd_data)
    );

    // An entry never written since reset reads as all zero.
    assign cur = tbl_valid_reg[slot_reg] ? gha_pkg::entry_t'(tbl_rd_data) : '0;

    // The handle names an issued slot with a matching generation.
    assign current = (slot_reg != '0)
                  && (gha_pkg::FILL_W'(slot_reg) < fresh_reg)
                  && (cur.gen == gha_pkg::handle_gen(req_reg.handle));

    // Operation logic for the item held in the datapath.
    always_comb
    begin
        nxt      = cur;
        tbl_wr   = 1'b0;
        push     = 1'b0;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        rsp_next = '0;
        unique case (req_reg.func)
            gha_pkg::FUNC_RESERVE:
            begin
                if (full_reg)
                begin
                    rsp_next.status = gha_pkg::STATUS_FULL;
                end
                else
                begin
                    nxt.pend            = 1'b1;
                    tbl_wr              = 1'b1;
                    rsp_next.new_handle = gha_pkg::make_handle(cur.gen, slot_reg);
                    rsp_next.is_pending = 1'b1;
                end
            end
            gha_pkg::FUNC_COMMIT:
            begin
                if (!current)
                begin
                    rsp_next.status = gha_pkg::STATUS_INVALID;
                end
                else
                begin
                    if (cur.pend)
                    begin
                        nxt.pend  = 1'b0;
                        nxt.alive = 1'b1;
                        cnt_inc   = !cur.alive;
                        tbl_wr    = 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = gha_pkg::STATUS_INVALID;
                    end
                    rsp_next.is_alive   = nxt.alive;
                    rsp_next.is_pending = nxt.pend;
                end
            end
            gha_pkg::FUNC_DESTROY:
            begin
                if (current && (cur.alive || cur.pend))
                begin
                    nxt.alive = 1'b0;
                    nxt.pend  = 1'b0;
                    nxt.gen   = gha_pkg::gen_t'(cur.gen + 1'b1);
                    tbl_wr    = 1'b1;
                    push      = (fill_reg < gha_pkg::FILL_W'(gha_pkg::SLOT_COUNT));
                    cnt_dec   = cur.alive && (count_reg != '0);
                end
                else
                begin
                    rsp_next.status = gha_pkg::STATUS_INVALID;
                end
            end
            default:
            begin
                if (!current)
                begin
                    rsp_next.status = gha_pkg::STATUS_INVALID;
                end
                else
                begin
                    rsp_next.is_alive   = cur.alive;
                    rsp_next.is_pending = cur.pend;
                end
            end
        endcase
        count_next = count_reg;
        if (cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cnt_dec)
        begin
            count_next = count_reg - 1'b1;
        end
        rsp_next.live_total = gha_pkg::LIVE_W'(count_next);
    end

    // Item payload and slot capture.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg  <= req;
            slot_reg <= accept_slot;
            full_reg <= is_reserve_in && (fill_reg == '0) && !fresh_avail;
        end
        else if (cmd.pop)
        begin
            slot_reg <= stack_rd_data;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Allocator bookkeeping and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            fresh_reg     <= gha_pkg::FILL_W'(1);
            count_reg     <= '0;
            tbl_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && stat.needs_pop)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
            else if (cmd.exec && push)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.accept && is_reserve_in && (fill_reg == '0) && fresh_avail)
            begin
                fresh_reg <= fresh_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                count_reg <= count_next;
                if (tbl_wr)
                begin
                    tbl_valid_reg[slot_reg] <= 1'b1;
                end
            end
            if (cmd.exec)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hdl/generational_handle_allocator_unit.sv]
// Sequence: the accepting edge registers the slot table read (for a reserve that pops
// the free stack, the stack read, then the table read of the popped slot); the update
// then writes the table and registers the result, waiting while the previous result
// still waits for ready. A new item is accepted only after the previous one's update.
// A waiting result sits in an output register while the next item is accepted.
// Reset (rst_n, asynchronous, active low) clears the control state, the counters and
// the per-slot written bits at once; no clearing pass runs.
module generational_handle_allocator_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  gha_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output gha_pkg::rsp_t rsp
);

    gha_pkg::ctrl_cmd_t  cmd;
    gha_pkg::dp_status_t stat;

    // Sequencing of each item.
    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Slot table, free stack, counters and output register.
    gha_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[hdl/gha_checker.sv]
module gha_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input gha_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input gha_pkg::rsp_t rsp
);

    // An offered item holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("offered item changed before acceptance");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // A full table issues no handle and reports no flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == gha_pkg::STATUS_FULL) |->
            (rsp.new_handle == '0) && !rsp.is_alive && !rsp.is_pending)
        else $error("full result carries a handle or flags");

    // An issued handle never names slot zero and is pending only.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.new_handle != '0) |->
            (gha_pkg::handle_slot(rsp.new_handle) != '0) && rsp.is_pending
            && !rsp.is_alive && (rsp.status == gha_pkg::STATUS_OK))
        else $error("issued handle malformed");

    // The status code is one of the defined three.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == gha_pkg::STATUS_OK)
            || (rsp.status == gha_pkg::STATUS_INVALID)
            || (rsp.status == gha_pkg::STATUS_FULL))
        else $error("undefined status code");

endmodule

bind generational_handle_allocator_unit gha_checker u_gha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[tb/handle_allocator_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the handle allocator, keeps its own copy of the
// slot table, predicts each reply and compares the replies in order.
module handle_allocator_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  gha_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  gha_pkg::rsp_t rsp,
    output int            mismatches,
    output int            awaiting,
    output int            replies_checked,
    output int            full_replies,
    output int            rejected_replies,
    output int            gen_wraps
);

    // Shadow copy of the allocator state.
    gha_pkg::gen_t              slot_gen   [gha_pkg::SLOT_COUNT];
    logic                       slot_alive [gha_pkg::SLOT_COUNT];
    logic                       slot_pend  [gha_pkg::SLOT_COUNT];
    gha_pkg::slot_t             free_slots [gha_pkg::SLOT_COUNT];
    gha_pkg::fill_t             free_fill;
    logic [gha_pkg::SLOT_BITS:0] fresh_slot;
    logic [gha_pkg::LIVE_W-1:0] live_count;

    // Replies predicted but not yet seen, oldest first.
    gha_pkg::rsp_t expected_replies[$];
    gha_pkg::rsp_t oldest;

    int mismatch_count = 0;
    int awaiting_count = 0;
    int checked_count  = 0;
    int full_count     = 0;
    int rejected_count = 0;
    int wrap_count     = 0;

    assign mismatches       = mismatch_count;
    assign awaiting         = awaiting_count;
    assign replies_checked  = checked_count;
    assign full_replies     = full_count;
    assign rejected_replies = rejected_count;
    assign gen_wraps        = wrap_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [gha_pkg::HANDLE_W-1:0] got,
                               input logic [gha_pkg::HANDLE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Applies one operation to the shadow table and returns the reply it should give.
    function automatic gha_pkg::rsp_t predict_allocation(input gha_pkg::req_t item);
        gha_pkg::rsp_t  reply;
        gha_pkg::slot_t slot;
        gha_pkg::gen_t  gen;
        logic           current;
        logic           got_slot;
        reply    = '0;
        slot     = item.handle[gha_pkg::SLOT_BITS-1:0];
        gen      = item.handle[gha_pkg::HANDLE_W-1:gha_pkg::SLOT_BITS];
        current  = (slot != '0) && ({1'b0, slot} < fresh_slot) && (slot_gen[slot] == gen);
        got_slot = 1'b0;

        if (item.func == gha_pkg::FUNC_RESERVE)
        begin
            // Freed slots are reused last-in first-out before fresh ones.
            if (free_fill != '0)
            begin
                free_fill = free_fill - 1'b1;
                slot      = free_slots[free_fill[gha_pkg::SLOT_BITS-1:0]];
                got_slot  = 1'b1;
            end
            else if (fresh_slot < gha_pkg::SLOT_COUNT)
            begin
                slot       = fresh_slot[gha_pkg::SLOT_BITS-1:0];
                fresh_slot = fresh_slot + 1'b1;
                got_slot   = 1'b1;
            end
            if (got_slot)
            begin
                slot_pend[slot]  = 1'b1;
                reply.new_handle = {slot_gen[slot], slot};
                reply.is_pending = 1'b1;
            end
            else
            begin
                reply.status = gha_pkg::STATUS_FULL;
            end
        end
        else if (!current)
        begin
            reply.status = gha_pkg::STATUS_INVALID;
        end
        else if (item.func == gha_pkg::FUNC_COMMIT)
        begin
            if (slot_pend[slot])
            begin
                slot_pend[slot] = 1'b0;
                if (!slot_alive[slot])
                begin
                    slot_alive[slot] = 1'b1;
                    live_count       = live_count + 1'b1;
                end
            end
            else
            begin
                reply.status = gha_pkg::STATUS_INVALID;
            end
            reply.is_alive   = slot_alive[slot];
            reply.is_pending = slot_pend[slot];
        end
        else if (item.func == gha_pkg::FUNC_DESTROY)
        begin
            if (slot_alive[slot] || slot_pend[slot])
            begin
                if (slot_alive[slot])
                begin
                    slot_alive[slot] = 1'b0;
                    if (live_count != '0)
                        live_count = live_count - 1'b1;
                end
                slot_pend[slot] = 1'b0;
                slot_gen[slot]  = slot_gen[slot] + 1'b1;
                if (slot_gen[slot] == '0)
                    wrap_count++;
                if (free_fill < gha_pkg::SLOT_COUNT)
                begin
                    free_slots[free_fill[gha_pkg::SLOT_BITS-1:0]] = slot;
                    free_fill = free_fill + 1'b1;
                end
            end
            else
            begin
                reply.status = gha_pkg::STATUS_INVALID;
            end
        end
        else
        begin
            reply.is_alive   = slot_alive[slot];
            reply.is_pending = slot_pend[slot];
        end

        reply.live_total = live_count;
        return reply;
    endfunction

    // Replies are checked before new items are predicted: an item accepted
    // at this edge cannot have its reply accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gha_pkg::SLOT_COUNT; i++)
            begin
                slot_gen[i]   = '0;
                slot_alive[i] = 1'b0;
                slot_pend[i]  = 1'b0;
                free_slots[i] = '0;
            end
            free_fill  = '0;
            fresh_slot = gha_pkg::FILL_W'(1);
            live_count = '0;
            expected_replies.delete();
            awaiting_count = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                checked_count++;
                if (rsp.status == gha_pkg::STATUS_FULL)
                    full_count++;
                if (rsp.status == gha_pkg::STATUS_INVALID)
                    rejected_count++;
                if (expected_replies.size() == 0)
                begin
                    report_mismatch("reply arrived with no item outstanding");
                end
                else
                begin
                    oldest = expected_replies.pop_front();
                    check_field("new_handle", rsp.new_handle, oldest.new_handle);
                    check_field("is_alive", gha_pkg::HANDLE_W'(rsp.is_alive),
                                gha_pkg::HANDLE_W'(oldest.is_alive));
                    check_field("is_pending", gha_pkg::HANDLE_W'(rsp.is_pending),
                                gha_pkg::HANDLE_W'(oldest.is_pending));
                    check_field("live_total", gha_pkg::HANDLE_W'(rsp.live_total),
                                gha_pkg::HANDLE_W'(oldest.live_total));
                    check_field("status", gha_pkg::HANDLE_W'(rsp.status),
                                gha_pkg::HANDLE_W'(oldest.status));
                end
            end
            if (req_valid && req_ready)
                expected_replies.insert(expected_replies.size(), predict_allocation(req));
            awaiting_count = expected_replies.size();
        end
    end

endmodule

[tb/tb_generational_handle_allocator_unit.sv]
`timescale 1ns / 1ps

module tb_generational_handle_allocator_unit;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int CHURN_ROUNDS = 460;
    localparam int POOL_CAP     = 80;

    typedef enum logic [1:0] {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    gha_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready;
    gha_pkg::rsp_t rsp;

    int mismatches;
    int awaiting;
    int replies_checked;
    int full_replies;
    int rejected_replies;
    int gen_wraps;

    int          items_sent  = 0;
    int unsigned cycle_count = 0;
    logic        req_burst   = 1'b0;
    logic        rsp_burst   = 1'b0;

    // Handles seen in replies, used to build commits, destroys and queries.
    logic [gha_pkg::HANDLE_W-1:0] handle_pool[$];
    logic [gha_pkg::HANDLE_W-1:0] last_issued = '0;

    generational_handle_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    handle_allocator_checker allocator_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req              (req),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp              (rsp),
        .mismatches       (mismatches),
        .awaiting         (awaiting),
        .replies_checked  (replies_checked),
        .full_replies     (full_replies),
        .rejected_replies (rejected_replies),
        .gen_wraps        (gen_wraps)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Collect issued handles from accepted replies.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready && rsp.status == gha_pkg::STATUS_OK
            && rsp.new_handle != '0)
        begin
            last_issued = rsp.new_handle;
            handle_pool.insert(handle_pool.size(), rsp.new_handle);
            if (handle_pool.size() > POOL_CAP)
                handle_pool.delete($urandom_range(0, POOL_CAP - 1));
        end
    end

    // Reply side: a random stall before each item, none in burst stretches.
    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = rsp_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
            @(negedge clk);
        end
    end

    function automatic logic [gha_pkg::HANDLE_W-1:0] compose_handle(input int gen,
                                                                    input int slot);
        return {gha_pkg::gen_t'(gen), gha_pkg::slot_t'(slot)};
    endfunction

    // Present one item after a random gap and wait until it is taken.
    task automatic send_item(input logic [gha_pkg::FUNC_W-1:0] func,
                             input logic [gha_pkg::HANDLE_W-1:0] handle);
        gha_pkg::req_t item;
        int            gap;
        item.func   = func;
        item.handle = handle;
        gap = req_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        items_sent++;
    endtask

    function automatic logic [gha_pkg::FUNC_W-1:0] draw_func(input mix_t mix);
        int pick;
        int reserve_pct;
        int destroy_pct;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                reserve_pct = 70;
                destroy_pct = 5;
            end
            MIX_DRAIN:
            begin
                reserve_pct = 10;
                destroy_pct = 55;
            end
            default:
            begin
                reserve_pct = 30;
                destroy_pct = 25;
            end
        endcase
        if (pick < reserve_pct)
            return gha_pkg::FUNC_RESERVE;
        if (pick < reserve_pct + destroy_pct)
            return gha_pkg::FUNC_DESTROY;
        if (pick < 85)
            return gha_pkg::FUNC_COMMIT;
        return gha_pkg::FUNC_QUERY;
    endfunction

    // One random item: mostly known handles, some with a wrong generation,
    // some fully random.
    task automatic send_random(input mix_t mix);
        logic [gha_pkg::FUNC_W-1:0]   func;
        logic [gha_pkg::HANDLE_W-1:0] handle;
        int                           idx;
        func = draw_func(mix);
        idx  = -1;
        if (handle_pool.size() == 0 || $urandom_range(0, 9) == 0)
        begin
            handle = gha_pkg::HANDLE_W'($urandom_range(0, 65535));
        end
        else
        begin
            idx    = $urandom_range(0, handle_pool.size() - 1);
            handle = handle_pool[idx];
            if ($urandom_range(0, 7) == 0)
                handle[gha_pkg::HANDLE_W-1:gha_pkg::SLOT_BITS] =
                    handle[gha_pkg::HANDLE_W-1:gha_pkg::SLOT_BITS]
                    + gha_pkg::gen_t'($urandom_range(1, 1023));
        end
        send_item(func, handle);
        // Destroyed handles mostly leave the pool; the rest stay as stale ones.
        if (func == gha_pkg::FUNC_DESTROY && idx >= 0 && idx < handle_pool.size()
            && $urandom_range(0, 3) != 0)
            handle_pool.delete(idx);
    endtask

    // A stretch of random items; a fill stretch runs until the table reports full or 200 items are sent.
    task automatic run_stretch(input mix_t mix, input int count);
        int fulls_at_start;
        int sent;
        fulls_at_start = full_replies;
        sent           = 0;
        req_burst      = ($urandom_range(0, 3) == 0);
        rsp_burst      = ($urandom_range(0, 3) == 0);
        if (mix == MIX_FILL)
        begin
            while (full_replies == fulls_at_start && sent < 200)
            begin
                send_random(mix);
                sent++;
            end
        end
        else
        begin
            repeat (count) send_random(mix);
        end
    endtask

    // Reserve then destroy the same slot again and again. The free stack hands
    // the slot straight back, so its generation climbs far above the others.
    task automatic churn_one_slot(input int rounds);
        logic [gha_pkg::HANDLE_W-1:0] issued;
        for (int i = 0; i < rounds; i++)
        begin
            if (i % 100 == 0)
            begin
                req_burst = ($urandom_range(0, 2) == 0);
                rsp_burst = ($urandom_range(0, 2) == 0);
            end
            send_item(gha_pkg::FUNC_RESERVE, gha_pkg::HANDLE_W'($urandom_range(0, 65535)));
            // The reserve was taken; withdraw it while its reply is awaited.
            req_valid <= 1'b0;
            do @(negedge clk); while (awaiting != 0);
            issued = last_issued;
            if ($urandom_range(0, 3) == 0)
                send_item(gha_pkg::FUNC_COMMIT, issued);
            send_item(gha_pkg::FUNC_DESTROY, issued);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: issue, commit, destroy, reuse, bad handles.
        send_item(gha_pkg::FUNC_RESERVE, '0);
        send_item(gha_pkg::FUNC_QUERY, '0);
        send_item(gha_pkg::FUNC_QUERY, compose_handle(1023, 0));
        send_item(gha_pkg::FUNC_QUERY, compose_handle(0, 5));
        send_item(gha_pkg::FUNC_COMMIT, compose_handle(0, 1));
        send_item(gha_pkg::FUNC_COMMIT, compose_handle(0, 1));
        send_item(gha_pkg::FUNC_QUERY, compose_handle(0, 1));
        send_item(gha_pkg::FUNC_QUERY, compose_handle(1, 1));
        send_item(gha_pkg::FUNC_DESTROY, compose_handle(0, 1));
        send_item(gha_pkg::FUNC_DESTROY, compose_handle(0, 1));
        // Current generation but neither alive nor pending.
        send_item(gha_pkg::FUNC_DESTROY, compose_handle(1, 1));
        send_item(gha_pkg::FUNC_COMMIT, compose_handle(1, 1));
        send_item(gha_pkg::FUNC_RESERVE, 16'hFFFF);
        send_item(gha_pkg::FUNC_RESERVE, '0);
        // Destroy straight from pending.
        send_item(gha_pkg::FUNC_DESTROY, compose_handle(1, 1));
        send_item(gha_pkg::FUNC_QUERY, 16'hFFFF);
        send_item(gha_pkg::FUNC_COMMIT, compose_handle(0, 2));
        send_item(gha_pkg::FUNC_DESTROY, compose_handle(0, 2));
        send_item(gha_pkg::FUNC_RESERVE, '0);
        send_item(gha_pkg::FUNC_RESERVE, '0);
        send_item(gha_pkg::FUNC_QUERY, compose_handle(0, 2));
        send_item(gha_pkg::FUNC_QUERY, compose_handle(2, 1));

        // Random part around a long single-slot churn.
        run_stretch(MIX_BALANCED, 60);
        run_stretch(MIX_FILL, 0);
        run_stretch(MIX_DRAIN, 60);
        run_stretch(mix_t'($urandom_range(0, 2)), 60);
        run_stretch(MIX_DRAIN, 40);
        churn_one_slot(CHURN_ROUNDS);
        run_stretch(mix_t'($urandom_range(0, 2)), 60);
        run_stretch(MIX_FILL, 0);
        run_stretch(MIX_BALANCED, 60);
        run_stretch(MIX_DRAIN, 80);
        run_stretch(MIX_BALANCED, 60);

        // Drain the outstanding replies, then let the bench idle before the summary.
        req_valid <= 1'b0;
        rsp_burst = 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d items and checked %0d replies in %0d cycles.",
                 items_sent, replies_checked, cycle_count);
        $display("Replies covered %0d table-full, %0d rejected handles, %0d generation wraps.",
                 full_replies, rejected_replies, gen_wraps);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
